// File: hw/rtl/mmnp_pkg.sv
// ============================================================================
// Music macro note parser package
// Shared types, character codes, tone tables and lookup functions.
// ============================================================================
`default_nettype none

package mmnp_pkg;

    // Result queue sizing.
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QCntW  = 3;

    // Width of the packed result data bus (35 payload bits, padded to bytes).
    localparam int OutDataW = 40;

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_LINE     = 3'd1,
        MODE_COMMENT  = 3'd2,
        MODE_AFTER_L  = 3'd3,
        MODE_AFTER_L1 = 3'd4,
        MODE_AFTER_R  = 3'd5,
        MODE_NOTE     = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NOTE    = 2'd0,
        KIND_REST    = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    // Character codes.
    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChNl    = 8'h0A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChApos  = 8'h27;
    localparam logic [7:0] ChDash  = 8'h2D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChOne   = 8'h31;
    localparam logic [7:0] ChTwo   = 8'h32;
    localparam logic [7:0] ChFour  = 8'h34;
    localparam logic [7:0] ChSix   = 8'h36;
    localparam logic [7:0] ChEight = 8'h38;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChA     = 8'h41;
    localparam logic [7:0] ChG     = 8'h47;
    localparam logic [7:0] ChL     = 8'h4C;
    localparam logic [7:0] ChR     = 8'h52;

    localparam logic [4:0] LenBad  = 5'd31;
    localparam logic [4:0] Len16   = 5'd16;
    localparam logic [3:0] OctMax  = 4'd15;
    localparam logic [3:0] OctTab  = 4'd2;
    localparam logic [2:0] LetMax  = 3'd6;

    // Tone period tables, [octave][letter]; unused rows and columns are zero.
    localparam logic [7:0] TabNat [4][8] = '{
        '{8'd152, 8'd135, 8'd255, 8'd227, 8'd202, 8'd191, 8'd170, 8'd0},
        '{8'd76,  8'd68,  8'd128, 8'd114, 8'd102, 8'd96,  8'd85,  8'd0},
        '{8'd38,  8'd34,  8'd64,  8'd57,  8'd51,  8'd48,  8'd43,  8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0}};
    localparam logic [7:0] TabSharp [4][8] = '{
        '{8'd143, 8'd0, 8'd241, 8'd214, 8'd0, 8'd180, 8'd161, 8'd0},
        '{8'd72,  8'd0, 8'd121, 8'd108, 8'd0, 8'd91,  8'd81,  8'd0},
        '{8'd36,  8'd0, 8'd60,  8'd54,  8'd0, 8'd45,  8'd40,  8'd0},
        '{8'd0,   8'd0, 8'd0,   8'd0,   8'd0, 8'd0,   8'd0,   8'd0}};
    localparam logic [7:0] TabFlat [4][8] = '{
        '{8'd161, 8'd143, 8'd0, 8'd241, 8'd214, 8'd0, 8'd180, 8'd0},
        '{8'd81,  8'd72,  8'd0, 8'd121, 8'd108, 8'd0, 8'd91,  8'd0},
        '{8'd40,  8'd36,  8'd0, 8'd60,  8'd54,  8'd0, 8'd45,  8'd0},
        '{8'd0,   8'd0,   8'd0, 8'd0,   8'd0,   8'd0, 8'd0,   8'd0}};

    typedef struct packed {
        logic [3:0] octave;
        logic [4:0] note_len;
        logic [4:0] sent_len;
        mode_t      mode;
        logic [2:0] letter;
        logic       sharp;
        logic       flat;
    } parse_state_t;

    typedef struct packed {
        kind_t      event_kind;
        logic [7:0] tone_period;
        logic       duration_changed;
        logic [7:0] note_duration;
        logic [9:0] rest_count;
        logic [7:0] bad_symbol;
        logic       last_of_run;
    } result_t;

    // Up to two results come out of one byte.
    typedef struct packed {
        logic v0;
        logic v1;
    } push_t;

    typedef struct packed {
        logic             room;
        logic [QCntW-1:0] count;
    } qstat_t;

    function automatic logic [7:0] period_of(input logic [3:0] oct, input logic [2:0] letter,
                                             input logic sharp, input logic flat);
        logic [7:0] ps;
        logic [7:0] pf;
        logic [7:0] pn;
        ps = TabSharp[oct[1:0]][letter];
        pf = TabFlat[oct[1:0]][letter];
        pn = TabNat[oct[1:0]][letter];
        if (oct > OctTab || letter > LetMax)
            return 8'd0;
        if (sharp && ps != 8'd0)
            return ps;
        if (flat && pf != 8'd0)
            return pf;
        return pn;
    endfunction

    function automatic logic [7:0] duration_of(input logic [4:0] len);
        unique case (len)
            5'd2:    return 8'd216;
            5'd3:    return 8'd162;
            5'd4:    return 8'd108;
            5'd8:    return 8'd54;
            5'd16:   return 8'd27;
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [9:0] rest_of(input logic [7:0] c);
        unique case (c)
            ChOne:   return 10'd640;
            ChTwo:   return 10'd320;
            ChFour:  return 10'd160;
            ChEight: return 10'd80;
            default: return 10'd0;
        endcase
    endfunction

    // Mode after a byte that was eaten as the argument of L or R.
    function automatic mode_t mode_after_consumed(input logic [7:0] c);
        if (c == ChNl)
            return MODE_START;
        if (c == ChNul)
            return MODE_COMMENT;
        return MODE_LINE;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/music_macro_note_parser.sv
// ============================================================================
// Music macro note parser
// Parses music-macro text one byte per beat and streams note, rest and
// unknown-character events.
// ============================================================================
//
// Channel  Dir  Beat content
// -------  ---  ----------------------------------------------------------
// s_*      in   one text byte (tdata[7:0] = symbol)
// m_*      out  one event: tuser = event_kind, tlast = last_of_run,
//               tdata = tone_period, duration_changed, note_duration,
//               rest_count, bad_symbol (from bit 0 up)
//
// A byte is taken into the input register, decoded against the parse state
// once the result queue has room, and its events are written into the result
// queue, whose head entry drives the result stream.
// Input beats are taken every cycle as long as the result queue has room for
// two events; a byte that both flushes a pending note and is an unknown
// character yields two events, so throughput is bounded by the result port
// at one event per cycle. Reset clears the parse state to line start,
// octave 1, length 8, nothing sent, and empties the queue. A stall downstream
// holds the input register once the four-entry queue can't take two events.
//
`default_nettype none

module music_macro_note_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] symbol
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] tone_period, [8] duration_changed, [16:9] note_duration,
    // [26:17] rest_count, [34:27] bad_symbol, [39:35] zero
    output logic [mmnp_pkg::OutDataW-1:0]      m_tdata,
    output logic [1:0]                         m_tuser,   // [1:0] event_kind
    output logic                               m_tlast    // last_of_run
);

    // Input register: one byte waiting for decode.
    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [7:0]              in_sym_reg;

    // Parse state.
    mmnp_pkg::parse_state_t  state_reg;
    mmnp_pkg::parse_state_t  state_next;

    mmnp_pkg::push_t         dec_push;
    mmnp_pkg::push_t         push;
    mmnp_pkg::result_t       res0;
    mmnp_pkg::result_t       res1;
    mmnp_pkg::qstat_t        qstat;
    logic                    fire;

    // The byte in the input register is decoded when the queue can take both
    // of the events it may produce.
    assign fire     = in_valid_reg && qstat.room;
    assign s_tready = !in_valid_reg || fire;

    assign in_valid_next = s_tvalid ? 1'b1 : (in_valid_reg && !fire);

    assign push.v0 = fire && dec_push.v0;
    assign push.v1 = fire && dec_push.v1;

    mmnp_decode u_decode (
        .st   (state_reg),
        .sym  (in_sym_reg),
        .nxt  (state_next),
        .push (dec_push),
        .res0 (res0),
        .res1 (res1)
    );

    mmnp_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res0     (res0),
        .res1     (res1),
        .stat     (qstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_sym_reg <= s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            state_reg.octave   <= 4'd1;
            state_reg.note_len <= 5'd8;
            state_reg.sent_len <= 5'd0;
            state_reg.mode     <= mmnp_pkg::MODE_START;
            state_reg.letter   <= 3'd0;
            state_reg.sharp    <= 1'b0;
            state_reg.flat     <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= in_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (qstat.count <= mmnp_pkg::QCntW'(mmnp_pkg::QDepth - 2)))
        else $error("byte decoded without queue room");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        dec_push.v1 |-> (dec_push.v0 && state_reg.mode == mmnp_pkg::MODE_NOTE))
        else $error("second event without a flushed note");

    a_note_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == mmnp_pkg::MODE_NOTE) |-> (state_reg.letter <= mmnp_pkg::LetMax))
        else $error("pending note letter out of range");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_sym_reg)))
        else $error("waiting byte lost or changed");

endmodule

`default_nettype wire

// File: hw/rtl/mmnp_decode.sv
// ============================================================================
// Music macro byte decoder
// Next parse state and up to two result items for one text byte.
// ============================================================================
`default_nettype none

module mmnp_decode (
    input  mmnp_pkg::parse_state_t st,
    input  logic [7:0]             sym,
    output mmnp_pkg::parse_state_t nxt,
    output mmnp_pkg::push_t        push,
    output mmnp_pkg::result_t      res0,
    output mmnp_pkg::result_t      res1
);

    logic              done;
    logic              note_chg;
    mmnp_pkg::result_t note_res;
    mmnp_pkg::result_t bad_res;

    // The pending note as it would be sent now (flat patched in below for '-').
    always_comb
    begin
        note_chg                  = (st.note_len != st.sent_len);
        note_res                  = '0;
        note_res.event_kind       = mmnp_pkg::KIND_NOTE;
        note_res.tone_period      = mmnp_pkg::period_of(st.octave, st.letter, st.sharp, st.flat);
        note_res.duration_changed = note_chg;
        note_res.note_duration    = note_chg ? mmnp_pkg::duration_of(st.note_len) : 8'd0;

        bad_res                   = '0;
        bad_res.event_kind        = mmnp_pkg::KIND_UNKNOWN;
        bad_res.bad_symbol        = sym;
    end

    always_comb
    begin
        nxt  = st;
        push = '0;
        res0 = '0;
        res1 = '0;
        done = 1'b0;

        unique case (st.mode)
            mmnp_pkg::MODE_COMMENT:
            begin
                if (sym == mmnp_pkg::ChNl)
                    nxt.mode = mmnp_pkg::MODE_START;
                done = 1'b1;
            end
            mmnp_pkg::MODE_AFTER_L:
            begin
                if (sym >= mmnp_pkg::ChZero && sym <= mmnp_pkg::ChNine)
                begin
                    nxt.note_len = {1'b0, sym[3:0]};
                    nxt.mode     = (sym == mmnp_pkg::ChOne) ? mmnp_pkg::MODE_AFTER_L1
                                                            : mmnp_pkg::MODE_LINE;
                end
                else
                begin
                    nxt.note_len = mmnp_pkg::LenBad;
                    nxt.mode     = mmnp_pkg::mode_after_consumed(sym);
                end
                done = 1'b1;
            end
            mmnp_pkg::MODE_AFTER_R:
            begin
                res0.event_kind = mmnp_pkg::KIND_REST;
                res0.rest_count = mmnp_pkg::rest_of(sym);
                push.v0         = 1'b1;
                nxt.mode        = mmnp_pkg::mode_after_consumed(sym);
                done            = 1'b1;
            end
            mmnp_pkg::MODE_AFTER_L1:
            begin
                nxt.mode = mmnp_pkg::MODE_LINE;
                if (sym == mmnp_pkg::ChSix)
                begin
                    nxt.note_len = mmnp_pkg::Len16;
                    done         = 1'b1;
                end
            end
            mmnp_pkg::MODE_NOTE:
            begin
                nxt.mode = mmnp_pkg::MODE_LINE;
                if (sym == mmnp_pkg::ChHash && !st.sharp)
                begin
                    nxt.sharp = 1'b1;
                    nxt.mode  = mmnp_pkg::MODE_NOTE;
                    done      = 1'b1;
                end
                else if (sym == mmnp_pkg::ChDash)
                begin
                    // A flat closes the note right away.
                    nxt.flat         = 1'b1;
                    nxt.sent_len     = st.note_len;
                    res0             = note_res;
                    res0.tone_period = mmnp_pkg::period_of(st.octave, st.letter, st.sharp, 1'b1);
                    push.v0          = 1'b1;
                    done             = 1'b1;
                end
                else
                begin
                    nxt.sent_len = st.note_len;
                    res0         = note_res;
                    push.v0      = 1'b1;
                end
            end
            default:
            begin
                // Line start, mid-line and the unused code go straight to the byte itself.
            end
        endcase

        if (!done)
        begin
            priority if (st.mode == mmnp_pkg::MODE_START && sym == mmnp_pkg::ChApos)
                nxt.mode = mmnp_pkg::MODE_COMMENT;
            else if (sym == mmnp_pkg::ChNl)
                nxt.mode = mmnp_pkg::MODE_START;
            else if (sym == mmnp_pkg::ChNul)
                nxt.mode = mmnp_pkg::MODE_COMMENT;
            else
            begin
                nxt.mode = mmnp_pkg::MODE_LINE;
                priority if (sym == mmnp_pkg::ChSpace || sym == mmnp_pkg::ChTab)
                begin
                end
                else if (sym == mmnp_pkg::ChLt)
                begin
                    if (st.octave != 4'd0)
                        nxt.octave = st.octave - 4'd1;
                end
                else if (sym == mmnp_pkg::ChGt)
                begin
                    if (st.octave != mmnp_pkg::OctMax)
                        nxt.octave = st.octave + 4'd1;
                end
                else if (sym == mmnp_pkg::ChL)
                    nxt.mode = mmnp_pkg::MODE_AFTER_L;
                else if (sym == mmnp_pkg::ChR)
                    nxt.mode = mmnp_pkg::MODE_AFTER_R;
                else if (sym >= mmnp_pkg::ChA && sym <= mmnp_pkg::ChG)
                begin
                    nxt.letter = 3'(sym - mmnp_pkg::ChA);
                    nxt.sharp  = 1'b0;
                    nxt.flat   = 1'b0;
                    nxt.mode   = mmnp_pkg::MODE_NOTE;
                end
                else if (push.v0)
                begin
                    res1    = bad_res;
                    push.v1 = 1'b1;
                end
                else
                begin
                    res0    = bad_res;
                    push.v0 = 1'b1;
                end
            end
        end

        if (push.v1)
            res1.last_of_run = 1'b1;
        else if (push.v0)
            res0.last_of_run = 1'b1;
    end

endmodule

`default_nettype wire

// File: hw/rtl/mmnp_outq.sv
// ============================================================================
// Music macro result queue
// Four-entry result queue, two writes and one read per cycle, drives the
// result stream.
// ============================================================================
`default_nettype none

module mmnp_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mmnp_pkg::push_t               push,
    input  mmnp_pkg::result_t             res0,
    input  mmnp_pkg::result_t             res1,
    output mmnp_pkg::qstat_t              stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mmnp_pkg::OutDataW-1:0] m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    mmnp_pkg::result_t               q_reg [mmnp_pkg::QDepth];
    logic [mmnp_pkg::QPtrW-1:0]      wr_ptr_reg;
    logic [mmnp_pkg::QPtrW-1:0]      wr_ptr_next;
    logic [mmnp_pkg::QPtrW-1:0]      wr_ptr_inc;
    logic [mmnp_pkg::QPtrW-1:0]      rd_ptr_reg;
    logic [mmnp_pkg::QPtrW-1:0]      rd_ptr_next;
    logic [mmnp_pkg::QCntW-1:0]      count_reg;
    logic [mmnp_pkg::QCntW-1:0]      count_next;
    logic                            pop;
    mmnp_pkg::result_t               head;

    assign pop        = m_tvalid && m_tready;
    assign wr_ptr_inc = wr_ptr_reg + mmnp_pkg::QPtrW'(1);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.v1)
            wr_ptr_next = wr_ptr_reg + mmnp_pkg::QPtrW'(2);
        else if (push.v0)
            wr_ptr_next = wr_ptr_inc;
        rd_ptr_next = pop ? rd_ptr_reg + mmnp_pkg::QPtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + mmnp_pkg::QCntW'(push.v0) + mmnp_pkg::QCntW'(push.v1)
                      - mmnp_pkg::QCntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
            q_reg[wr_ptr_reg] <= res0;
        if (push.v1)
            q_reg[wr_ptr_inc] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Room for two more items, counted without the pop of this cycle.
    assign stat.room  = (count_reg <= mmnp_pkg::QCntW'(mmnp_pkg::QDepth - 2));
    assign stat.count = count_reg;

    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = head.event_kind;
    assign m_tlast  = head.last_of_run;
    assign m_tdata  = {5'd0, head.bad_symbol, head.rest_count, head.note_duration,
                       head.duration_changed, head.tone_period};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mmnp_pkg::QCntW'(mmnp_pkg::QDepth))
        else $error("result queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != mmnp_pkg::QCntW'(mmnp_pkg::QDepth))
        |-> ((wr_ptr_reg - rd_ptr_reg) == count_reg[mmnp_pkg::QPtrW-1:0]))
        else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire
